>>> rtl/core/u16u8_pkg.sv
// Package for the UTF-16 to UTF-8 transcoder: code constants, the encoded
// byte-group type and the code point encoder. No dependencies.
`default_nettype none

package u16u8_pkg;

   localparam logic [15:0] BOM_UNIT       = 16'hFEFF;
   localparam logic [15:0] SURR_LO_UNIT   = 16'hD800;
   localparam logic [15:0] SURR_HI_UNIT   = 16'hDFFF;
   localparam logic [15:0] LOW_SURR_MASK  = 16'hDC00;
   localparam logic [20:0] PLANE1_BASE    = 21'h10000;
   localparam logic [20:0] REPLACEMENT_CP = 21'h0FFFD;
   localparam logic [20:0] LIMIT_1B       = 21'h00080;
   localparam logic [20:0] LIMIT_2B       = 21'h00800;
   localparam logic [20:0] LIMIT_3B       = 21'h10000;
   localparam logic [7:0]  LEAD_4B        = 8'b11110000;
   localparam logic [7:0]  LEAD_3B        = 8'b11100000;
   localparam logic [7:0]  LEAD_2B        = 8'b11000000;
   localparam logic [7:0]  CONT_BYTE      = 8'h80;

   // One encoded code point: bytes in output order, index of the final byte.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
   } byte_group_type;

   function automatic byte_group_type encode_cp(input logic [20:0] cp);
      byte_group_type g;
      g = '0;
      if (cp < LIMIT_1B) begin
         g.bytes[0] = {1'b0, cp[6:0]};
         g.last_idx = 2'd0;
      end else if (cp < LIMIT_2B) begin
         g.bytes[0] = LEAD_2B | {3'b000, cp[10:6]};
         g.bytes[1] = CONT_BYTE | {2'b00, cp[5:0]};
         g.last_idx = 2'd1;
      end else if (cp < LIMIT_3B) begin
         g.bytes[0] = LEAD_3B | {4'b0000, cp[15:12]};
         g.bytes[1] = CONT_BYTE | {2'b00, cp[11:6]};
         g.bytes[2] = CONT_BYTE | {2'b00, cp[5:0]};
         g.last_idx = 2'd2;
      end else begin
         g.bytes[0] = LEAD_4B | {5'b00000, cp[20:18]};
         g.bytes[1] = CONT_BYTE | {2'b00, cp[17:12]};
         g.bytes[2] = CONT_BYTE | {2'b00, cp[11:6]};
         g.bytes[3] = CONT_BYTE | {2'b00, cp[5:0]};
         g.last_idx = 2'd3;
      end
      return g;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/utf16_to_utf8_transcoder_unit.sv
// UTF-16 to UTF-8 transcoder, top level.
// Groups pass stage A, then the serializer, before output; 0 to 4 bytes per unit.
// Throughput: one byte per cycle from the serializer while rsp_ready is high;
// a unit is taken every cycle if each gives one byte or none, with rsp_ready high.
// Reset (synchronous): clears the held surrogate and empties both stages.
// Depends on u16u8_pkg.
`default_nettype none

module utf16_to_utf8_transcoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_code_unit,
   input  wire logic        req_first_unit,
   input  wire logic        req_last_unit,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_byte
);
   import u16u8_pkg::*;

   logic           pend_ff, pend_in;
   logic [9:0]     held_ff, held_in;
   logic           a_valid_ff, a_valid_in;
   byte_group_type a_group_ff, a_group_in;
   logic           b_valid_ff, b_valid_in;
   byte_group_type b_group_ff, b_group_in;
   logic [1:0]     idx_ff, idx_in;

   logic           req_xfer, rsp_xfer, b_done, a_move;
   logic           eff_pend, is_surr, emit;
   logic [20:0]    cp;

   assign rsp_valid     = b_valid_ff;
   assign rsp_out_byte  = b_group_ff.bytes[idx_ff];
   assign rsp_last_byte = (idx_ff == b_group_ff.last_idx);
   assign rsp_xfer      = rsp_valid && rsp_ready;
   assign b_done        = rsp_xfer && rsp_last_byte;
   assign a_move        = a_valid_ff && (!b_valid_ff || b_done);
   assign req_ready     = !a_valid_ff || a_move;
   assign req_xfer      = req_valid && req_ready;

   assign eff_pend = pend_ff && !req_first_unit;
   assign is_surr  = (req_code_unit >= SURR_LO_UNIT) && (req_code_unit <= SURR_HI_UNIT);

   // Decode the unit against the held surrogate and update pairing state.
   always_comb begin
      pend_in = pend_ff;
      held_in = held_ff;
      emit    = 1'b0;
      cp      = {5'd0, req_code_unit};
      if (req_xfer) begin
         if (req_first_unit) begin
            pend_in = 1'b0;
            held_in = '0;
         end
         if (req_first_unit && !req_last_unit && req_code_unit == BOM_UNIT) begin
            emit = 1'b0;
         end else if (eff_pend) begin
            pend_in = 1'b0;
            held_in = '0;
            emit    = 1'b1;
            if ((req_code_unit & LOW_SURR_MASK) == LOW_SURR_MASK) begin
               cp = {1'b0, held_ff, req_code_unit[9:0]} + PLANE1_BASE;
            end else begin
               cp = REPLACEMENT_CP;
            end
         end else if (is_surr) begin
            if (req_last_unit) begin
               emit = 1'b1;
               cp   = REPLACEMENT_CP;
            end else begin
               pend_in = 1'b1;
               held_in = req_code_unit[9:0];
            end
         end else begin
            emit = 1'b1;
         end
      end
   end

   // Hold the encoded group in stage A until the serializer frees up.
   always_comb begin
      a_valid_in = a_valid_ff;
      a_group_in = a_group_ff;
      if (a_move) begin
         a_valid_in = 1'b0;
      end
      if (emit) begin
         a_valid_in = 1'b1;
         a_group_in = encode_cp(cp);
      end
   end

   // Serializer: one byte per transfer; reload from stage A when done or empty.
   always_comb begin
      b_valid_in = b_valid_ff;
      b_group_in = b_group_ff;
      idx_in     = idx_ff;
      if (rsp_xfer && !rsp_last_byte) begin
         idx_in = idx_ff + 2'd1;
      end
      if (b_done) begin
         b_valid_in = 1'b0;
      end
      if (a_move) begin
         b_valid_in = 1'b1;
         b_group_in = a_group_ff;
         idx_in     = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= 1'b0;
         held_ff    <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         idx_ff     <= '0;
      end else begin
         pend_ff    <= pend_in;
         held_ff    <= held_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         idx_ff     <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      a_group_ff <= a_group_in;
      b_group_ff <= b_group_in;
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (idx_ff <= b_group_ff.last_idx))
      else $error("serializer index past the end of its byte group");

   a_lead_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && idx_ff == 2'd0) |-> (rsp_out_byte[7:6] != 2'b10))
      else $error("group opens with a continuation byte");

   a_cont_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && idx_ff != 2'd0) |-> (rsp_out_byte[7:6] == 2'b10))
      else $error("continuation byte lacks 10 prefix");

   a_pair_clears: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && pend_ff && !req_first_unit) |=> !pend_ff)
      else $error("held surrogate survived its second unit");

endmodule

`default_nettype wire
